// ===== src/tsm_pkg.sv =====
// ============================================================================
// tsm_pkg
// Shared constants for the trackball sphere map: register codes, register
// widths and reset values, output field widths.
// ============================================================================
`default_nettype none

package tsm_pkg;

    // default parameter values
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 14;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BALL_RADIUS = 2'd2;

    // register widths and reset values
    localparam int CTR_BITS = 12;
    localparam int RAD_BITS = 11;

    localparam logic [CTR_BITS-1:0] CENTER_X_RST    = 12'd160;
    localparam logic [CTR_BITS-1:0] CENTER_Y_RST    = 12'd216;
    localparam logic [RAD_BITS-1:0] BALL_RADIUS_RST = 11'd106;
    localparam logic [RAD_BITS-1:0] RADIUS_MIN      = 11'd2;

    // output field widths
    localparam int SX_BITS = 16;
    localparam int SZ_BITS = 15;

endpackage

`default_nettype wire

// ===== src/tsm_if.sv =====
// ============================================================================
// tsm_if
// Valid/ready channels of the trackball sphere map: touch words in, sphere
// words out, and the register write channel.
// ============================================================================
`default_nettype none

interface tsm_in_if #(
    parameter int COORD_BITS = tsm_pkg::DEF_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] touch_x;
    logic [COORD_BITS-1:0] touch_y;

    modport source (output valid, output touch_x, output touch_y, input ready);
    modport sink   (input valid, input touch_x, input touch_y, output ready);
endinterface

interface tsm_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [tsm_pkg::SX_BITS-1:0] sphere_x;
    logic signed [tsm_pkg::SX_BITS-1:0] sphere_y;
    logic [tsm_pkg::SZ_BITS-1:0]        sphere_z;

    modport source (output valid, output sphere_x, output sphere_y, output sphere_z,
                    input ready);
    modport sink   (input valid, input sphere_x, input sphere_y, input sphere_z,
                    output ready);
endinterface

interface tsm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tsm_pkg::CFG_IDX_BITS-1:0]  index;
    logic [tsm_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/tsm_sqrt_pipe.sv =====
// ============================================================================
// tsm_sqrt_pipe
// Pipelined floor square root: one root bit per register stage, with a side
// word and a valid bit carried alongside. All stages advance on i_en.
// ============================================================================
`default_nettype none

module tsm_sqrt_pipe #(
    parameter int W      = 38,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [W-1:0]      i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_vld,
    output logic [W/2-1:0]         o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int H = W / 2;

    logic [H-1:0]      r_vld;
    logic [W-1:0]      r_rad  [H];
    logic [H+1:0]      r_rem  [H];
    logic [H-1:0]      r_root [H];
    logic [SIDE_W-1:0] r_side [H];

    for (genvar k = 0; k < H; k++) begin : g_stage
        logic              w_vin;
        logic [W-1:0]      w_rad_in;
        logic [H+1:0]      w_rem_in;
        logic [H-1:0]      w_root_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [H+3:0]      w_acc;
        logic [H+3:0]      w_trial;
        logic [H+3:0]      w_diff;
        logic [H+1:0]      n_rem;
        logic [H-1:0]      n_root;

        if (k == 0) begin : g_first
            assign w_vin     = i_vld;
            assign w_rad_in  = i_rad;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vin     = r_vld[k-1];
            assign w_rad_in  = r_rad[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_side_in = r_side[k-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb begin
            w_acc   = {w_rem_in, w_rad_in[W-1:W-2]};
            w_trial = {2'b00, w_root_in, 2'b01};
            w_diff  = w_acc - w_trial;
            if (w_acc >= w_trial) begin
                n_rem  = w_diff[H+1:0];
                n_root = {w_root_in[H-2:0], 1'b1};
            end else begin
                n_rem  = w_acc[H+1:0];
                n_root = {w_root_in[H-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {w_rad_in[W-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[H-1];
    assign o_root = r_root[H-1];
    assign o_side = r_side[H-1];

endmodule

`default_nettype wire

// ===== src/tsm_div_pipe.sv =====
// ============================================================================
// tsm_div_pipe
// Pipelined restoring divider: one quotient bit per register stage for
// several numerators over one shared divisor, side word carried along.
// ============================================================================
`default_nettype none

module tsm_div_pipe #(
    parameter int N      = 39,
    parameter int D      = 21,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_vld,
    input  wire logic [LANES-1:0][N-1:0]   i_num,
    input  wire logic [D-1:0]              i_den,
    input  wire logic [SIDE_W-1:0]         i_side,
    output logic                           o_vld,
    output logic [LANES-1:0][N-1:0]        o_quo,
    output logic [SIDE_W-1:0]              o_side
);
    logic [N-1:0]                r_vld;
    logic [LANES-1:0][N-1:0]     r_nq   [N];
    logic [LANES-1:0][D-1:0]     r_rem  [N];
    logic [D-1:0]                r_den  [N];
    logic [SIDE_W-1:0]           r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                    w_vin;
        logic [LANES-1:0][N-1:0] w_nq_in;
        logic [LANES-1:0][D-1:0] w_rem_in;
        logic [D-1:0]            w_den_in;
        logic [SIDE_W-1:0]       w_side_in;
        logic [LANES-1:0][D:0]   w_acc;
        logic [LANES-1:0][D:0]   w_diff;
        logic [LANES-1:0][N-1:0] n_nq;
        logic [LANES-1:0][D-1:0] n_rem;

        if (k == 0) begin : g_first
            assign w_vin     = i_vld;
            assign w_nq_in   = i_num;
            assign w_rem_in  = '0;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vin     = r_vld[k-1];
            assign w_nq_in   = r_nq[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_side_in = r_side[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_acc[l]  = {w_rem_in[l], w_nq_in[l][N-1]};
                w_diff[l] = w_acc[l] - {1'b0, w_den_in};
                if (w_acc[l] >= {1'b0, w_den_in}) begin
                    n_rem[l] = w_diff[l][D-1:0];
                    n_nq[l]  = {w_nq_in[l][N-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_acc[l][D-1:0];
                    n_nq[l]  = {w_nq_in[l][N-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k]   <= n_nq;
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_den_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_quo  = r_nq[N-1];
    assign o_side = r_side[N-1];

endmodule

`default_nettype wire

// ===== src/trackball_sphere_map.sv =====
// ============================================================================
// trackball_sphere_map
// Maps a touch pixel onto a unit trackball sphere in Q2.FRAC_BITS.
// ============================================================================
// Takes one touch word per cycle while the output is not stalled and returns
// one sphere word per touch, in order. It is built around two square root
// pipelines (one root bit per stage) and two divider pipelines (one quotient
// bit per stage). When the output is stalled the whole pipeline holds, and
// the input stage still takes one word if it is empty. Register writes take
// effect on the next accepted touch word and must be made while the pipeline
// is empty.
`default_nettype none

module trackball_sphere_map #(
    parameter int COORD_BITS = tsm_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = tsm_pkg::DEF_FRAC_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsm_in_if.sink      i_touch,
    tsm_cfg_if.sink     i_cfg,
    tsm_out_if.source   o_sphere
);
    import tsm_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int R   = RAD_BITS;
    localparam int XM  = R + 9;          // Q.8 magnitude after clamping
    localparam int W1  = 2 * C + 18;     // first sqrt radicand
    localparam int H1  = W1 / 2;         // length in Q.8
    localparam int N1  = R + C + 16;     // first divide numerator
    localparam int W2  = 2 * R + 16;     // depth radicand
    localparam int H2  = W2 / 2;         // depth in Q.8
    localparam int N3  = XM + FRAC_BITS; // final divide numerator
    localparam int D3  = R + 8;          // r * 256
    localparam int SQW = 2 * XM + 1;

    typedef struct packed {
        logic [C-1:0] mx;
        logic [C-1:0] my;
        logic         sx;
        logic         sy;
        logic [R-1:0] r;
        logic [R-1:0] safe;
        logic         clamp;
    } t_len_side;

    typedef struct packed {
        logic [XM-1:0] xm;
        logic [XM-1:0] ym;
        logic          sx;
        logic          sy;
        logic [R-1:0]  r;
    } t_dep_side;

    typedef struct packed {
        logic sx;
        logic sy;
    } t_sgn_side;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CTR_BITS-1:0] r_cx;
    logic [CTR_BITS-1:0] r_cy;
    logic [R-1:0]        r_rad;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= CENTER_X_RST;
            r_cy  <= CENTER_Y_RST;
            r_rad <= BALL_RADIUS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CENTER_X:    r_cx  <= i_cfg.data[CTR_BITS-1:0];
                CFG_CENTER_Y:    r_cy  <= i_cfg.data[CTR_BITS-1:0];
                CFG_BALL_RADIUS: r_rad <= i_cfg.data[R-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: everything moves unless the output word is stuck
    // ------------------------------------------------------------------
    logic w_en;
    logic w_load1;
    logic r_o_vld;
    logic r_s1_vld;

    assign w_en          = !r_o_vld || o_sphere.ready;
    assign w_load1       = w_en || !r_s1_vld;
    assign i_touch.ready = w_load1;

    // ------------------------------------------------------------------
    // S1: offsets from the centre, y flipped; radius floor
    // ------------------------------------------------------------------
    logic [C-1:0]        w_cx, w_cy;
    logic signed [C:0]   n_dx, n_dy;
    logic [R-1:0]        n_r;
    logic signed [C:0]   r_s1_dx, r_s1_dy;
    logic [R-1:0]        r_s1_r, r_s1_safe;

    assign w_cx = C'(r_cx);
    assign w_cy = C'(r_cy);

    always_comb begin
        n_dx = $signed({1'b0, i_touch.touch_x}) - $signed({1'b0, w_cx});
        n_dy = $signed({1'b0, w_cy}) - $signed({1'b0, i_touch.touch_y});
        n_r  = (r_rad < RADIUS_MIN) ? RADIUS_MIN : r_rad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_load1) begin
            r_s1_vld <= i_touch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_s1_dx   <= n_dx;
            r_s1_dy   <= n_dy;
            r_s1_r    <= n_r;
            r_s1_safe <= n_r - R'(1);
        end
    end

    // ------------------------------------------------------------------
    // S2: magnitudes squared, safe radius squared
    // ------------------------------------------------------------------
    logic [C-1:0]   w_mx, w_my;
    logic           r_s2_vld;
    logic [2*C-1:0] r_s2_dx2, r_s2_dy2;
    logic [2*R-1:0] r_s2_safe2;
    t_len_side      r_s2_side;

    always_comb begin
        w_mx = r_s1_dx[C] ? C'(-r_s1_dx) : C'(r_s1_dx);
        w_my = r_s1_dy[C] ? C'(-r_s1_dy) : C'(r_s1_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_dx2        <= w_mx * w_mx;
            r_s2_dy2        <= w_my * w_my;
            r_s2_safe2      <= r_s1_safe * r_s1_safe;
            r_s2_side.mx    <= w_mx;
            r_s2_side.my    <= w_my;
            r_s2_side.sx    <= r_s1_dx[C];
            r_s2_side.sy    <= r_s1_dy[C];
            r_s2_side.r     <= r_s1_r;
            r_s2_side.safe  <= r_s1_safe;
            r_s2_side.clamp <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // S3: squared length and clamp decision
    // ------------------------------------------------------------------
    logic [2*C:0] w_s;
    t_len_side    w_s3_side;
    logic         r_s3_vld;
    logic [2*C:0] r_s3_s;
    t_len_side    r_s3_side;

    assign w_s = {1'b0, r_s2_dx2} + {1'b0, r_s2_dy2};

    always_comb begin
        w_s3_side       = r_s2_side;
        w_s3_side.clamp = (2*C+2*R+1)'(w_s) > (2*C+2*R+1)'(r_s2_safe2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_s    <= w_s;
            r_s3_side <= w_s3_side;
        end
    end

    // ------------------------------------------------------------------
    // length in Q.8: floor sqrt(S * 2^16)
    // ------------------------------------------------------------------
    logic              w_sq1_vld;
    logic [H1-1:0]     w_len;
    logic [$bits(t_len_side)-1:0] w_sq1_side_b;
    t_len_side         w_sq1_side;

    tsm_sqrt_pipe #(
        .W      (W1),
        .SIDE_W ($bits(t_len_side))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s3_vld),
        .i_rad   ({1'b0, r_s3_s, 16'd0}),
        .i_side  (r_s3_side),
        .o_vld   (w_sq1_vld),
        .o_root  (w_len),
        .o_side  (w_sq1_side_b)
    );

    assign w_sq1_side = t_len_side'(w_sq1_side_b);

    // ------------------------------------------------------------------
    // S4: (r-1) * |d| products for the clamp scaling
    // ------------------------------------------------------------------
    logic          r_s4_vld;
    logic [R+C-1:0] r_s4_px, r_s4_py;
    logic [H1-1:0] r_s4_len;
    t_len_side     r_s4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_en) begin
            r_s4_vld <= w_sq1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_px   <= w_sq1_side.safe * w_sq1_side.mx;
            r_s4_py   <= w_sq1_side.safe * w_sq1_side.my;
            r_s4_len  <= w_len;
            r_s4_side <= w_sq1_side;
        end
    end

    // ------------------------------------------------------------------
    // clamp scaling: (r-1) * |d| * 2^16 / L
    // ------------------------------------------------------------------
    logic                  w_dv1_vld;
    logic [1:0][N1-1:0]    w_dv1_num;
    logic [1:0][N1-1:0]    w_dv1_quo;
    logic [$bits(t_len_side)-1:0] w_dv1_side_b;
    t_len_side             w_dv1_side;

    assign w_dv1_num[0] = {r_s4_px, 16'd0};
    assign w_dv1_num[1] = {r_s4_py, 16'd0};

    tsm_div_pipe #(
        .N      (N1),
        .D      (H1),
        .LANES  (2),
        .SIDE_W ($bits(t_len_side))
    ) u_clamp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s4_vld),
        .i_num   (w_dv1_num),
        .i_den   (r_s4_len),
        .i_side  (r_s4_side),
        .o_vld   (w_dv1_vld),
        .o_quo   (w_dv1_quo),
        .o_side  (w_dv1_side_b)
    );

    assign w_dv1_side = t_len_side'(w_dv1_side_b);

    // ------------------------------------------------------------------
    // S5: pick clamped or plain Q.8 magnitudes
    // ------------------------------------------------------------------
    logic      r_s5_vld;
    t_dep_side r_s5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s5_vld <= w_dv1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_dv1_side.clamp) begin
                r_s5_side.xm <= w_dv1_quo[0][XM-1:0];
                r_s5_side.ym <= w_dv1_quo[1][XM-1:0];
            end else begin
                r_s5_side.xm <= XM'({w_dv1_side.mx, 8'd0});
                r_s5_side.ym <= XM'({w_dv1_side.my, 8'd0});
            end
            r_s5_side.sx <= w_dv1_side.sx;
            r_s5_side.sy <= w_dv1_side.sy;
            r_s5_side.r  <= w_dv1_side.r;
        end
    end

    // ------------------------------------------------------------------
    // S6: squares for the depth radicand
    // ------------------------------------------------------------------
    logic            r_s6_vld;
    logic [2*XM-1:0] r_s6_x2, r_s6_y2;
    logic [2*R-1:0]  r_s6_rr;
    t_dep_side       r_s6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (w_en) begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_x2   <= r_s5_side.xm * r_s5_side.xm;
            r_s6_y2   <= r_s5_side.ym * r_s5_side.ym;
            r_s6_rr   <= r_s5_side.r * r_s5_side.r;
            r_s6_side <= r_s5_side;
        end
    end

    // ------------------------------------------------------------------
    // S7: x'^2 + y'^2
    // ------------------------------------------------------------------
    logic           r_s7_vld;
    logic [SQW-1:0] r_s7_sum;
    logic [2*R-1:0] r_s7_rr;
    t_dep_side      r_s7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (w_en) begin
            r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_sum  <= {1'b0, r_s6_x2} + {1'b0, r_s6_y2};
            r_s7_rr   <= r_s6_rr;
            r_s7_side <= r_s6_side;
        end
    end

    // ------------------------------------------------------------------
    // S8: depth radicand r^2*2^16 - sum, floored at zero
    // ------------------------------------------------------------------
    logic [SQW-1:0] w_big;
    logic [SQW-1:0] w_rdiff;
    logic           r_s8_vld;
    logic [W2-1:0]  r_s8_rad;
    t_dep_side      r_s8_side;

    assign w_big   = SQW'({r_s7_rr, 16'd0});
    assign w_rdiff = w_big - r_s7_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
        end else if (w_en) begin
            r_s8_vld <= r_s7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_rad  <= (r_s7_sum > w_big) ? '0 : w_rdiff[W2-1:0];
            r_s8_side <= r_s7_side;
        end
    end

    // ------------------------------------------------------------------
    // depth in Q.8
    // ------------------------------------------------------------------
    logic          w_sq2_vld;
    logic [H2-1:0] w_zq;
    logic [$bits(t_dep_side)-1:0] w_sq2_side_b;
    t_dep_side     w_sq2_side;

    tsm_sqrt_pipe #(
        .W      (W2),
        .SIDE_W ($bits(t_dep_side))
    ) u_depth_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s8_vld),
        .i_rad   (r_s8_rad),
        .i_side  (r_s8_side),
        .o_vld   (w_sq2_vld),
        .o_root  (w_zq),
        .o_side  (w_sq2_side_b)
    );

    assign w_sq2_side = t_dep_side'(w_sq2_side_b);

    // ------------------------------------------------------------------
    // unit scaling: q8 * 2^FRAC_BITS / (r * 256)
    // ------------------------------------------------------------------
    logic               w_dv2_vld;
    logic [2:0][N3-1:0] w_dv2_num;
    logic [2:0][N3-1:0] w_dv2_quo;
    t_sgn_side          w_dv2_in_side;
    logic [$bits(t_sgn_side)-1:0] w_dv2_side_b;
    t_sgn_side          w_dv2_side;

    assign w_dv2_num[0]    = {w_sq2_side.xm, FRAC_BITS'(0)};
    assign w_dv2_num[1]    = {w_sq2_side.ym, FRAC_BITS'(0)};
    assign w_dv2_num[2]    = {XM'(w_zq), FRAC_BITS'(0)};
    assign w_dv2_in_side.sx = w_sq2_side.sx;
    assign w_dv2_in_side.sy = w_sq2_side.sy;

    tsm_div_pipe #(
        .N      (N3),
        .D      (D3),
        .LANES  (3),
        .SIDE_W ($bits(t_sgn_side))
    ) u_unit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq2_vld),
        .i_num   (w_dv2_num),
        .i_den   ({w_sq2_side.r, 8'd0}),
        .i_side  (w_dv2_in_side),
        .o_vld   (w_dv2_vld),
        .o_quo   (w_dv2_quo),
        .o_side  (w_dv2_side_b)
    );

    assign w_dv2_side = t_sgn_side'(w_dv2_side_b);

    // ------------------------------------------------------------------
    // output register: signs back on, truncated to field widths
    // ------------------------------------------------------------------
    logic [SX_BITS-1:0] w_qx, w_qy;
    logic [SX_BITS-1:0] r_o_x, r_o_y;
    logic [SZ_BITS-1:0] r_o_z;

    assign w_qx = w_dv2_quo[0][SX_BITS-1:0];
    assign w_qy = w_dv2_quo[1][SX_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= w_dv2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_x <= w_dv2_side.sx ? -w_qx : w_qx;
            r_o_y <= w_dv2_side.sy ? -w_qy : w_qy;
            r_o_z <= w_dv2_quo[2][SZ_BITS-1:0];
        end
    end

    assign o_sphere.valid    = r_o_vld;
    assign o_sphere.sphere_x = $signed(r_o_x);
    assign o_sphere.sphere_y = $signed(r_o_y);
    assign o_sphere.sphere_z = r_o_z;

`ifndef SYNTHESIS
    localparam int Z_ONE = 1 << FRAC_BITS;

    // a held input stage keeps its word while the pipeline is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_en |=> r_s1_vld && $stable(r_s1_dx) && $stable(r_s1_dy))
        else $error("input stage word changed during stall");

    // depth never exceeds the radius in Q.8
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq2_vld |-> w_zq <= {w_sq2_side.r, 8'd0})
        else $error("depth larger than radius");

    // unit depth never exceeds one
    a_unit_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && (FRAC_BITS <= 14) |-> int'(r_o_z) <= Z_ONE)
        else $error("sphere_z above one");
`endif

endmodule

`default_nettype wire
